### src/wildcard_word_filter_defines.svh
// Assertion macros for the wildcard word filter.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef WILDCARD_WORD_FILTER_DEFINES_SVH
`define WILDCARD_WORD_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define WWF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("wwf assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define WWF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("wwf assertion failed");

`else

`define WWF_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define WWF_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### src/wwf_pkg.sv
// Shared types, constants and helpers for the wildcard word filter.
// No dependencies; used by every other file of the block except the defines header.
package wwf_pkg;

	// Defaults for the top-level parameters
	localparam int PATTERN_MAX_DEF  = 16;
	localparam int MAX_WORD_LEN_DEF = 32;

	// Fixed field widths
	localparam int PAT_SLOTS = 16;  // pattern bytes held by the two 64-bit registers
	localparam int CHAR_W    = 8;
	localparam int PLEN_W    = 5;
	localparam int LIMIT_W   = 6;
	localparam int REG_W     = 64;
	localparam int PADDR_W   = 5;
	localparam int IDX_LSB   = 3;   // registers sit on 8-byte boundaries

	// Wildcard characters
	localparam logic [CHAR_W-1:0] WILD_ONE = 8'h3F;  // '?'
	localparam logic [CHAR_W-1:0] WILD_ANY = 8'h2A;  // '*'

	// Register map
	typedef enum logic [1:0] {
		REG_PAT_LOW  = 2'd0,
		REG_PAT_HIGH = 2'd1,
		REG_PAT_LEN  = 2'd2,
		REG_LIMIT    = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [PAT_SLOTS-1:0][CHAR_W-1:0] pat_chars;
		logic [PLEN_W-1:0]                pat_len;
		logic [LIMIT_W-1:0]               limit;
	} cfg_t;

	typedef struct packed {
		logic pattern_matched;
		logic length_fits;
		logic word_accepted;
	} res_t;

	// Lower-case ASCII letters fold to upper case, everything else is kept
	function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

endpackage

### src/wwf_ifs.sv
// Valid/ready channel interfaces: character words in, verdict words out.
// Depends on wwf_pkg for field widths.
interface wwf_char_if import wwf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] word_char;
	logic              char_present;
	logic              last_char;

	modport source(output valid, word_char, char_present, last_char, input ready);
	modport sink(input valid, word_char, char_present, last_char, output ready);
endinterface

interface wwf_verdict_if;
	logic valid;
	logic ready;
	logic pattern_matched;
	logic length_fits;
	logic word_accepted;

	modport source(output valid, pattern_matched, length_fits, word_accepted, input ready);
	modport sink(input valid, pattern_matched, length_fits, word_accepted, output ready);
endinterface

### src/wwf_cfg_regs.sv
// APB-style configuration registers: pattern bytes, pattern length, length limit.
// Depends on wwf_pkg.
module wwf_cfg_regs import wwf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]   pwdata,
	output logic [REG_W-1:0]   prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:IDX_LSB]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_PAT_LOW:  cfg_q.pat_chars[PAT_SLOTS/2-1:0]         <= pwdata;
				REG_PAT_HIGH: cfg_q.pat_chars[PAT_SLOTS-1:PAT_SLOTS/2] <= pwdata;
				REG_PAT_LEN:  cfg_q.pat_len <= pwdata[PLEN_W-1:0];
				REG_LIMIT:    cfg_q.limit   <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (idx)
			REG_PAT_LOW:  prdata = cfg_q.pat_chars[PAT_SLOTS/2-1:0];
			REG_PAT_HIGH: prdata = cfg_q.pat_chars[PAT_SLOTS-1:PAT_SLOTS/2];
			REG_PAT_LEN:  prdata = REG_W'(cfg_q.pat_len);
			REG_LIMIT:    prdata = REG_W'(cfg_q.limit);
			default:      prdata = '0;
		endcase
	end

endmodule

### src/wwf_match_core.sv
// Input register and per-character update of the active pattern-position set.
// Depends on wwf_pkg and wwf_char_if.
module wwf_match_core import wwf_pkg::*; #(
	parameter int PATTERN_MAX  = PATTERN_MAX_DEF,
	parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	wwf_char_if.sink    chars,
	input  cfg_t        cfg,
	input  logic        slot_free,
	output logic        push,
	output res_t        res
);

	localparam int POS_W = PATTERN_MAX + 1;
	localparam int IDX_W = (POS_W > 1) ? $clog2(POS_W) : 1;
	localparam int LEN_W = $clog2(MAX_WORD_LEN + 2);
	localparam int CMP_W = LIMIT_W + 1;
	localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_WORD_LEN + 1);

	// input stage
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              present_s1;
	logic              last_s1;

	// word state
	logic [POS_W-1:0] active_q;
	logic             start_q;
	logic [LEN_W-1:0] len_q;

	logic                   go;
	logic [PLEN_W-1:0]      n;
	logic [PATTERN_MAX-1:0] star;
	logic [PATTERN_MAX-1:0] step;
	logic [POS_W-1:0]       base_set;
	logic [POS_W-1:0]       adv_set;
	logic [POS_W-1:0]       nxt_set;
	logic [LEN_W-1:0]       len_base;
	logic [LEN_W-1:0]       len_nxt;

	// Closure over '*': position j is reached if j-1 is reached and holds '*'.
	// Solved as a parallel-prefix carry network, log2 levels deep.
	function automatic logic [POS_W-1:0] close_star(
		input logic [POS_W-1:0]       set,
		input logic [PATTERN_MAX-1:0] stars
	);
		logic [POS_W-1:0] g;
		logic [POS_W-1:0] p;
		logic [POS_W-1:0] g_n;
		logic [POS_W-1:0] p_n;
		g = set;
		p = {stars, 1'b0};
		for (int d = 1; d < POS_W; d = d * 2) begin
			g_n = g;
			p_n = p;
			for (int j = d; j < POS_W; j++) begin
				g_n[j] = g[j] | (p[j] & g[j-d]);
				p_n[j] = p[j] & p[j-d];
			end
			g = g_n;
			p = p_n;
		end
		return g;
	endfunction

	// handshake: a word-final item waits for room in the result register
	assign go          = valid_s1 && (!last_s1 || slot_free);
	assign chars.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1    <= chars.word_char;
			present_s1 <= chars.char_present;
			last_s1    <= chars.last_char;
		end
	end

	// effective pattern length
	assign n = (cfg.pat_len > PLEN_W'(PATTERN_MAX)) ? PLEN_W'(PATTERN_MAX) : cfg.pat_len;

	// per-position decode of the pattern against the current character
	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			star[i] = (PLEN_W'(i) < n) && (cfg.pat_chars[i] == WILD_ANY);
			step[i] = (PLEN_W'(i) < n) && (cfg.pat_chars[i] != WILD_ANY) &&
			          ((cfg.pat_chars[i] == WILD_ONE) ||
			           (fold(cfg.pat_chars[i]) == fold(char_s1)));
		end
	end

	// next position set and length
	assign base_set = start_q ? close_star(POS_W'(1), star) : active_q;
	assign adv_set  = {1'b0, base_set[PATTERN_MAX-1:0] & star} |
	                  {base_set[PATTERN_MAX-1:0] & step, 1'b0};
	assign nxt_set  = present_s1 ? close_star(adv_set, star) : base_set;

	assign len_base = start_q ? '0 : len_q;
	assign len_nxt  = (present_s1 && (len_base != LEN_SAT)) ? len_base + 1'b1 : len_base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			start_q  <= 1'b1;
			len_q    <= '0;
		end else if (go) begin
			active_q <= nxt_set;
			start_q  <= last_s1;
			len_q    <= len_nxt;
		end
	end

	// verdict for a word-final item
	assign push                = go && last_s1;
	assign res.pattern_matched = nxt_set[n[IDX_W-1:0]];
	assign res.length_fits     = CMP_W'(len_nxt) <= CMP_W'(cfg.limit);
	assign res.word_accepted   = res.pattern_matched && res.length_fits;

endmodule

### src/wwf_result_reg.sv
// Output register for verdict words, drives the outgoing valid/ready channel.
// Depends on wwf_pkg and wwf_verdict_if.
module wwf_result_reg import wwf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  res_t          res,
	output logic          slot_free,
	wwf_verdict_if.source verdicts
);

	logic valid_q;
	res_t res_q;

	assign slot_free = !valid_q || verdicts.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && slot_free) begin
			res_q <= res;
		end
	end

	assign verdicts.valid           = valid_q;
	assign verdicts.pattern_matched = res_q.pattern_matched;
	assign verdicts.length_fits     = res_q.length_fits;
	assign verdicts.word_accepted   = res_q.word_accepted;

endmodule

### src/wildcard_word_filter.sv
// Wildcard word filter: top level with configuration port and word channels.
// Depends on wwf_pkg, wwf_ifs, wwf_cfg_regs, wwf_match_core, wwf_result_reg.
//
// Takes one character word per clock and, on the word that carries last_char,
// emits one verdict word (pattern_matched, length_fits, word_accepted) through
// the input register and then the result register. The rate is set by the loop
// through the active-position register: each character updates the set of
// reachable pattern positions, including the '*' closure, combinationally.
// The input side stalls only while a finished verdict is waiting and not taken.
// Registers (64-bit APB, byte address 8*i): pattern bytes 0-7, pattern bytes
// 8-15, pattern length, length limit; write them only while no word is in flight.
`include "wildcard_word_filter_defines.svh"

module wildcard_word_filter import wwf_pkg::*; #(
	parameter int PATTERN_MAX  = PATTERN_MAX_DEF,
	parameter int MAX_WORD_LEN = MAX_WORD_LEN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	wwf_char_if.sink           chars,
	wwf_verdict_if.source      verdicts,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [REG_W-1:0]   pwdata,
	output logic [REG_W-1:0]   prdata,
	output logic               pready
);

	cfg_t cfg;
	logic slot_free;
	logic push;
	res_t res;

	wwf_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	wwf_match_core #(
		.PATTERN_MAX  (PATTERN_MAX),
		.MAX_WORD_LEN (MAX_WORD_LEN)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars),
		.cfg       (cfg),
		.slot_free (slot_free),
		.push      (push),
		.res       (res)
	);

	wwf_result_reg u_res (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.res       (res),
		.slot_free (slot_free),
		.verdicts  (verdicts)
	);

	// input stalls only behind a verdict that is held up downstream
	`WWF_ASSERT_IMP(a_stall_cause, clk, arst_n, !chars.ready, verdicts.valid && !verdicts.ready)
	// the combined verdict agrees with its two parts
	`WWF_ASSERT_IMP(a_accept_and, clk, arst_n, verdicts.valid, verdicts.word_accepted == (verdicts.pattern_matched && verdicts.length_fits))
	// a pattern-length write lands in the register decode
	`WWF_ASSERT_NXT(a_plen_write, clk, arst_n, psel && penable && pwrite && (paddr[PADDR_W-1:IDX_LSB] == REG_PAT_LEN), cfg.pat_len == $past(pwdata[PLEN_W-1:0]))

endmodule
